// File: hdl/diamond_path_gradient_derivative_macros.svh
// Assertion macros for the diamond path gradient derivative block.
// Used by the port checker; depends on nothing else.
`ifndef DIAMOND_PATH_GRADIENT_DERIVATIVE_MACROS_SVH
`define DIAMOND_PATH_GRADIENT_DERIVATIVE_MACROS_SVH

// consequent must hold whenever the antecedent holds
`define DPGD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// expression must never be true outside reset
`define DPGD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: hdl/dpgd_pkg.sv
// Shared widths, codes, sideband type and role table for the diamond path
// gradient derivative pipeline. No dependencies.
package dpgd_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W = 33;
   localparam int WGT_W = 18;
   localparam int WGT_FRAC = 16;
   localparam int K_W = 19;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int DEN_W = CROSS_W + 1;
   localparam int DIV_W = DEN_W + 1;
   localparam int KP_W = K_W + DIFF_W;
   localparam int SUM_W = KP_W + 2;
   localparam int QUO_W = 33;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int PIPE_LATENCY = 4 + QUO_W + 1 + 1;

   localparam logic signed [K_W-1:0] K_ONE = K_W'(1 << WGT_FRAC);
   localparam logic [QUO_W-1:0] SAT_POS = QUO_W'(64'h7FFF_FFFF);
   localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(64'h8000_0000);

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_UNCOVERED = 2'd1;
   localparam logic [1:0] STATUS_ZERO_AREA = 2'd2;

   localparam logic [1:0] FACE_N = 2'd0;
   localparam logic [1:0] FACE_E = 2'd1;
   localparam logic [1:0] FACE_S = 2'd2;
   localparam logic [1:0] FACE_W = 2'd3;

   localparam logic [3:0] POS_C = 4'd0;
   localparam logic [3:0] POS_N = 4'd1;
   localparam logic [3:0] POS_E = 4'd2;
   localparam logic [3:0] POS_S = 4'd3;
   localparam logic [3:0] POS_W = 4'd4;
   localparam logic [3:0] POS_NE = 4'd5;
   localparam logic [3:0] POS_NW = 4'd6;
   localparam logic [3:0] POS_SE = 4'd7;
   localparam logic [3:0] POS_SW = 4'd8;

   localparam logic [2:0] ROLE_NONE = 3'd0;
   localparam logic [2:0] ROLE_CENTER = 3'd1;
   localparam logic [2:0] ROLE_NEIGHBOUR = 3'd2;
   localparam logic [2:0] ROLE_LEFT = 3'd3;
   localparam logic [2:0] ROLE_RIGHT = 3'd4;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic [1:0] status;
   } side_type;

   function automatic logic [2:0] role_lookup(input logic [1:0] face, input logic [3:0] pos);
      logic [2:0] role;
      role = ROLE_NONE;
      if (pos == POS_C) begin
         role = ROLE_CENTER;
      end else begin
         case (face)
            FACE_N: begin
               case (pos)
                  POS_N: role = ROLE_NEIGHBOUR;
                  POS_W, POS_NW: role = ROLE_LEFT;
                  POS_E, POS_NE: role = ROLE_RIGHT;
                  default: role = ROLE_NONE;
               endcase
            end
            FACE_E: begin
               case (pos)
                  POS_E: role = ROLE_NEIGHBOUR;
                  POS_N, POS_NE: role = ROLE_LEFT;
                  POS_S, POS_SE: role = ROLE_RIGHT;
                  default: role = ROLE_NONE;
               endcase
            end
            FACE_S: begin
               case (pos)
                  POS_S: role = ROLE_NEIGHBOUR;
                  POS_E, POS_SE: role = ROLE_LEFT;
                  POS_W, POS_SW: role = ROLE_RIGHT;
                  default: role = ROLE_NONE;
               endcase
            end
            default: begin
               case (pos)
                  POS_W: role = ROLE_NEIGHBOUR;
                  POS_S, POS_SW: role = ROLE_LEFT;
                  POS_N, POS_NW: role = ROLE_RIGHT;
                  default: role = ROLE_NONE;
               endcase
            end
         endcase
      end
      return role;
   endfunction

endpackage

// File: hdl/dpgd_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared
// divisor, with overflow flag and a sideband that rides along. Uses dpgd_pkg.
module dpgd_div
   import dpgd_pkg::*;
#(
   parameter int NUM_W = 72
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [1:0][NUM_W-1:0] in_num,
   input  logic [DIV_W-1:0] in_den,
   input  side_type in_side,
   output logic out_valid,
   output logic [1:0][QUO_W-1:0] out_quo,
   output logic [1:0] out_ovf,
   output side_type out_side
);

   localparam int CMP_W = (NUM_W > DIV_W + QUO_W) ? NUM_W + 1 : DIV_W + QUO_W + 1;

   logic v_ff [0:QUO_W];
   logic [1:0][NUM_W-1:0] r_ff [0:QUO_W];
   logic [1:0][QUO_W-1:0] q_ff [0:QUO_W];
   logic [1:0] ovf_ff [0:QUO_W];
   logic [DIV_W-1:0] d_ff [0:QUO_W];
   side_type side_ff [0:QUO_W];
   logic [1:0] ovf_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ovf_in[l] = CMP_W'(in_num[l]) >= (CMP_W'(in_den) << QUO_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      r_ff[0] <= in_num;
      q_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
      d_ff[0] <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - 1 - j;
      logic [CMP_W-1:0] sub_w;
      logic [1:0][NUM_W-1:0] r_in;
      logic [1:0][QUO_W-1:0] q_in;

      always_comb begin
         sub_w = CMP_W'(d_ff[j]) << BIT;
         for (int l = 0; l < 2; l++) begin
            q_in[l] = q_ff[j][l];
            r_in[l] = r_ff[j][l];
            if (CMP_W'(r_ff[j][l]) >= sub_w) begin
               r_in[l] = NUM_W'(CMP_W'(r_ff[j][l]) - sub_w);
               q_in[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else begin
            v_ff[j+1] <= v_ff[j];
         end
         r_ff[j+1] <= r_in;
         q_ff[j+1] <= q_in;
         ovf_ff[j+1] <= ovf_ff[j];
         d_ff[j+1] <= d_ff[j];
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_quo = q_ff[QUO_W];
   assign out_ovf = ovf_ff[QUO_W];
   assign out_side = side_ff[QUO_W];

endmodule

// File: hdl/diamond_path_gradient_derivative.sv
// Top level of the diamond path gradient derivative pipeline.
// Uses dpgd_pkg and dpgd_div.
//
// One face item is taken on every cycle that start is high; busy is always low.
// Each result appears on rsp_* with rsp_valid high for one cycle, in order,
// after passing through the registered stages for differences, products,
// cross sums and area, the input and step registers of the one-bit-per-stage
// divider, and one output register. The receiver cannot stall the block.
module diamond_path_gradient_derivative
   import dpgd_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_W-1:0] req_own_center_x,
   input  logic signed [COORD_W-1:0] req_own_center_y,
   input  logic signed [COORD_W-1:0] req_neighbour_center_x,
   input  logic signed [COORD_W-1:0] req_neighbour_center_y,
   input  logic signed [COORD_W-1:0] req_left_node_x,
   input  logic signed [COORD_W-1:0] req_left_node_y,
   input  logic signed [COORD_W-1:0] req_right_node_x,
   input  logic signed [COORD_W-1:0] req_right_node_y,
   input  logic signed [WGT_W-1:0] req_left_weight,
   input  logic signed [WGT_W-1:0] req_right_weight,
   input  logic [1:0] req_face_side,
   input  logic [3:0] req_cell_position,
   output logic rsp_valid,
   output logic signed [COORD_W-1:0] rsp_deriv_x,
   output logic signed [COORD_W-1:0] rsp_deriv_y,
   output logic [1:0] rsp_status
);

   localparam int SHIFT = 2 * FRACTION_BITS - WGT_FRAC;
   localparam int MAG_W = SUM_W;
   localparam int NUM_W = (MAG_W + SHIFT + 2 > DEN_W + 2) ? MAG_W + SHIFT + 2 : DEN_W + 2;

   // stage 1: differences and coefficients
   logic s1_valid_ff;
   logic signed [DIFF_W-1:0] rcx_ff, rcy_ff, lcx_ff, lcy_ff, lbx_ff, lby_ff, rbx_ff, rby_ff;
   logic signed [K_W-1:0] ka_ff, kb_ff, kc_ff, kd_ff;
   logic signed [K_W-1:0] ka_in, kb_in, kc_in, kd_in, wl_k, wr_k;
   logic s1_uncov_ff;
   logic [2:0] role;

   assign busy = 1'b0;

   always_comb begin
      role = role_lookup(req_face_side, req_cell_position);
      wl_k = K_W'(req_left_weight);
      wr_k = K_W'(req_right_weight);
      ka_in = '0;
      kb_in = '0;
      kc_in = '0;
      kd_in = '0;
      case (role)
         ROLE_CENTER: begin
            ka_in = K_ONE + wr_k;
            kb_in = wr_k;
            kc_in = wl_k;
            kd_in = K_ONE + wl_k;
         end
         ROLE_NEIGHBOUR: begin
            ka_in = wr_k;
            kb_in = K_ONE + wr_k;
            kc_in = K_ONE + wl_k;
            kd_in = wl_k;
         end
         ROLE_LEFT: begin
            kc_in = wl_k;
            kd_in = wl_k;
         end
         ROLE_RIGHT: begin
            ka_in = wr_k;
            kb_in = wr_k;
         end
         default: begin
            ka_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      rcx_ff <= DIFF_W'(req_right_node_x) - DIFF_W'(req_own_center_x);
      rcy_ff <= DIFF_W'(req_right_node_y) - DIFF_W'(req_own_center_y);
      lcx_ff <= DIFF_W'(req_left_node_x) - DIFF_W'(req_own_center_x);
      lcy_ff <= DIFF_W'(req_left_node_y) - DIFF_W'(req_own_center_y);
      lbx_ff <= DIFF_W'(req_left_node_x) - DIFF_W'(req_neighbour_center_x);
      lby_ff <= DIFF_W'(req_left_node_y) - DIFF_W'(req_neighbour_center_y);
      rbx_ff <= DIFF_W'(req_right_node_x) - DIFF_W'(req_neighbour_center_x);
      rby_ff <= DIFF_W'(req_right_node_y) - DIFF_W'(req_neighbour_center_y);
      ka_ff <= ka_in;
      kb_ff <= kb_in;
      kc_ff <= kc_in;
      kd_ff <= kd_in;
      s1_uncov_ff <= (role == ROLE_NONE);
   end

   // stage 2: products
   logic s2_valid_ff, s2_uncov_ff;
   logic signed [PROD_W-1:0] c1a_ff, c1b_ff, c2a_ff, c2b_ff;
   logic signed [KP_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff, qa_ff, qb_ff, qc_ff, qd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_uncov_ff <= s1_uncov_ff;
      c1a_ff <= PROD_W'(rcx_ff) * PROD_W'(lcy_ff);
      c1b_ff <= PROD_W'(rcy_ff) * PROD_W'(lcx_ff);
      c2a_ff <= PROD_W'(lbx_ff) * PROD_W'(rby_ff);
      c2b_ff <= PROD_W'(lby_ff) * PROD_W'(rbx_ff);
      pa_ff <= KP_W'(ka_ff) * KP_W'(rcy_ff);
      pb_ff <= KP_W'(kb_ff) * KP_W'(rby_ff);
      pc_ff <= KP_W'(kc_ff) * KP_W'(lby_ff);
      pd_ff <= KP_W'(kd_ff) * KP_W'(lcy_ff);
      qa_ff <= KP_W'(ka_ff) * KP_W'(rcx_ff);
      qb_ff <= KP_W'(kb_ff) * KP_W'(rbx_ff);
      qc_ff <= KP_W'(kc_ff) * KP_W'(lbx_ff);
      qd_ff <= KP_W'(kd_ff) * KP_W'(lcx_ff);
   end

   // stage 3: cross products and weighted normal sums
   logic s3_valid_ff, s3_uncov_ff;
   logic signed [CROSS_W-1:0] cr1_ff, cr2_ff;
   logic signed [SUM_W-1:0] sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_uncov_ff <= s2_uncov_ff;
      cr1_ff <= CROSS_W'(c1a_ff) - CROSS_W'(c1b_ff);
      cr2_ff <= CROSS_W'(c2a_ff) - CROSS_W'(c2b_ff);
      sx_ff <= SUM_W'(pa_ff) - SUM_W'(pb_ff) + SUM_W'(pc_ff) - SUM_W'(pd_ff);
      sy_ff <= SUM_W'(qb_ff) - SUM_W'(qa_ff) + SUM_W'(qd_ff) - SUM_W'(qc_ff);
   end

   // stage 4: area, magnitudes, rounded numerators
   logic s4_valid_ff;
   logic [1:0][NUM_W-1:0] num_ff;
   logic [DIV_W-1:0] den_ff;
   side_type side_ff;
   logic [CROSS_W-1:0] a1, a2;
   logic [DEN_W-1:0] den_w;
   logic [MAG_W-1:0] mx, my;
   side_type side_in;

   always_comb begin
      a1 = cr1_ff[CROSS_W-1] ? CROSS_W'(-cr1_ff) : CROSS_W'(cr1_ff);
      a2 = cr2_ff[CROSS_W-1] ? CROSS_W'(-cr2_ff) : CROSS_W'(cr2_ff);
      den_w = DEN_W'(a1) + DEN_W'(a2);
      mx = sx_ff[SUM_W-1] ? MAG_W'(-sx_ff) : MAG_W'(sx_ff);
      my = sy_ff[SUM_W-1] ? MAG_W'(-sy_ff) : MAG_W'(sy_ff);
      side_in.neg_x = sx_ff[SUM_W-1];
      side_in.neg_y = sy_ff[SUM_W-1];
      if (s3_uncov_ff) begin
         side_in.status = STATUS_UNCOVERED;
      end else if (den_w == '0) begin
         side_in.status = STATUS_ZERO_AREA;
      end else begin
         side_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      num_ff[0] <= (NUM_W'(mx) << (SHIFT + 1)) + NUM_W'(den_w);
      num_ff[1] <= (NUM_W'(my) << (SHIFT + 1)) + NUM_W'(den_w);
      den_ff <= {den_w, 1'b0};
      side_ff <= side_in;
   end

   // divider
   logic div_valid;
   logic [1:0][QUO_W-1:0] div_quo;
   logic [1:0] div_ovf;
   side_type div_side;

   dpgd_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(s4_valid_ff),
      .in_num(num_ff),
      .in_den(den_ff),
      .in_side(side_ff),
      .out_valid(div_valid),
      .out_quo(div_quo),
      .out_ovf(div_ovf),
      .out_side(div_side)
   );

   // output: saturate, apply sign, zero on bad status
   logic rsp_valid_ff;
   logic signed [COORD_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [1:0] status_ff;
   logic [QUO_W-1:0] lim_x, lim_y, m_x, m_y;

   always_comb begin
      lim_x = div_side.neg_x ? SAT_NEG : SAT_POS;
      lim_y = div_side.neg_y ? SAT_NEG : SAT_POS;
      m_x = (div_ovf[0] || div_quo[0] > lim_x) ? lim_x : div_quo[0];
      m_y = (div_ovf[1] || div_quo[1] > lim_y) ? lim_y : div_quo[1];
      dx_in = div_side.neg_x ? COORD_W'(-m_x) : COORD_W'(m_x);
      dy_in = div_side.neg_y ? COORD_W'(-m_y) : COORD_W'(m_y);
      if (div_side.status != STATUS_OK) begin
         dx_in = '0;
         dy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      status_ff <= div_side.status;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_deriv_x = dx_ff;
   assign rsp_deriv_y = dy_ff;
   assign rsp_status = status_ff;

endmodule

// File: hdl/dpgd_checker.sv
// Port-level checker for diamond_path_gradient_derivative, bound to the top.
// Uses dpgd_pkg and diamond_path_gradient_derivative_macros.svh.
`include "diamond_path_gradient_derivative_macros.svh"

module dpgd_checker
   import dpgd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic signed [COORD_W-1:0] rsp_deriv_x,
   input logic signed [COORD_W-1:0] rsp_deriv_y,
   input logic [1:0] rsp_status
);

   `DPGD_ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `DPGD_ASSERT_IMPLY(a_rsp_follows_transfer, clock, reset, rsp_valid, $past(start && !busy, PIPE_LATENCY))
   `DPGD_ASSERT_IMPLY(a_bad_status_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_deriv_x == '0 && rsp_deriv_y == '0)
   `DPGD_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_UNCOVERED || rsp_status == STATUS_ZERO_AREA)

endmodule

bind diamond_path_gradient_derivative dpgd_checker u_dpgd_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_deriv_x(rsp_deriv_x),
   .rsp_deriv_y(rsp_deriv_y),
   .rsp_status(rsp_status)
);
